>>> sv/assert_macros.svh
// Assertion helper macros used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ebcpu_pkg.sv
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Shared types and constants of the eight-bit CPU subset executor.
// ----------------------------------------------------------------------------
package ebcpu_pkg;

    localparam int ADDR_BITS_DEF = 16;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EXEC  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;
    localparam logic [7:0]  PREFIX_CB = 8'hCB;
    localparam logic [7:0]  CB_RL_C   = 8'h11;
    localparam logic [7:0]  CB_BIT7H  = 8'h7C;

    localparam logic [7:0] OP_DEC_B  = 8'h05;
    localparam logic [7:0] OP_LD_BN  = 8'h06;
    localparam logic [7:0] OP_LD_CN  = 8'h0E;
    localparam logic [7:0] OP_LD_DE  = 8'h11;
    localparam logic [7:0] OP_RLA    = 8'h17;
    localparam logic [7:0] OP_LD_ADE = 8'h1A;
    localparam logic [7:0] OP_JR_NZ  = 8'h20;
    localparam logic [7:0] OP_LD_HL  = 8'h21;
    localparam logic [7:0] OP_LDI    = 8'h22;
    localparam logic [7:0] OP_INC_HL = 8'h23;
    localparam logic [7:0] OP_LD_SP  = 8'h31;
    localparam logic [7:0] OP_LDD    = 8'h32;
    localparam logic [7:0] OP_LD_AN  = 8'h3E;
    localparam logic [7:0] OP_LD_CA  = 8'h4F;
    localparam logic [7:0] OP_LD_HLA = 8'h77;
    localparam logic [7:0] OP_XOR_A  = 8'hAF;
    localparam logic [7:0] OP_POP_BC = 8'hC1;
    localparam logic [7:0] OP_PUSH   = 8'hC5;
    localparam logic [7:0] OP_RET    = 8'hC9;
    localparam logic [7:0] OP_CALL   = 8'hCD;
    localparam logic [7:0] OP_LDH    = 8'hE0;
    localparam logic [7:0] OP_LD_CIA = 8'hE2;

    localparam logic [3:0] FZ = 4'd8;
    localparam logic [3:0] FN = 4'd4;
    localparam logic [3:0] FH = 4'd2;
    localparam logic [3:0] FC = 4'd1;

    // One memory request from the sequencer.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] program_counter;
        logic [15:0] stack_pointer;
        logic [7:0]  accumulator;
        logic [3:0]  flag_bits;
        logic        halted_flag;
        logic [4:0]  cycle_cost;
        logic [7:0]  executed_opcode;
    } result_t;

endpackage

>>> sv/eight_bit_cpu_subset_executor_core.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_subset_executor_core
// Eight-bit CPU subset executor around an internal byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per beat: tuser = kind, tdata = {data, address}
//   (address lowest). kind 0 writes a memory byte, kind 2 reads one, kind 1
//   executes one instruction at the program counter.
//   m_axis returns one result per request with the register state after it.
// Steps and throughput:
//   write: one step; read: a read and a result step; execute: one opcode
//   fetch, up to two operand reads, one execute step, and one more write
//   step for PUSH and CALL; CALL is the longest. The single memory port
//   sets these steps; a request is taken in the cycle the previous result
//   leaves, so writes stream at one per cycle while the receiver keeps up.
// Reset clears the state, the register file, the pending result and the
// halted state; memory is undefined until written. When the receiver
// stalls, the result is held and no new request is taken.
// ----------------------------------------------------------------------------
module eight_bit_cpu_subset_executor_core import ebcpu_pkg::*; #(
    parameter int ADDRESS_BITS = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    input  logic [23:0] s_axis_tdata,  // address[15:0], data[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // read_data, program_counter, stack_pointer,
                                       // accumulator, flag_bits, halted_flag,
                                       // cycle_cost, executed_opcode
);
    mem_req_t   mreq;
    logic [7:0] mrdata;
    result_t    res;

    ebcpu_mem #(.ADDRESS_BITS(ADDRESS_BITS)) u_mem (
        .aclk(aclk), .req(mreq), .rdata(mrdata)
    );

    ebcpu_seq u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_kind(s_axis_tuser), .in_addr(s_axis_tdata[15:0]),
        .in_data(s_axis_tdata[23:16]),
        .mreq(mreq), .mrdata(mrdata),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    // pack fields, lowest first
    assign m_axis_tdata = {6'd0, res.executed_opcode, res.cycle_cost, res.halted_flag,
                           res.flag_bits, res.accumulator, res.stack_pointer,
                           res.program_counter, res.read_data};
endmodule

>>> sv/ebcpu_mem.sv
// ----------------------------------------------------------------------------
// ebcpu_mem
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ebcpu_mem import ebcpu_pkg::*; #(
    parameter int ADDRESS_BITS = ADDR_BITS_DEF
) (
    input  logic       aclk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);
    logic [7:0] mem_array [2**ADDRESS_BITS];

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem_array[req.addr[ADDRESS_BITS-1:0]] <= req.wdata;
            end else begin
                rdata <= mem_array[req.addr[ADDRESS_BITS-1:0]];
            end
        end
    end
endmodule

>>> sv/ebcpu_seq.sv
// ----------------------------------------------------------------------------
// ebcpu_seq
// Instruction sequencer: fetches, decodes and executes one request at a time
// through the byte memory, holding the register file.
// ----------------------------------------------------------------------------
module ebcpu_seq import ebcpu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_kind,
    input  logic [15:0] in_addr,
    input  logic [7:0]  in_data,
    output mem_req_t    mreq,
    input  logic [7:0]  mrdata,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    typedef enum logic [3:0] {
        S_IDLE, S_OP, S_B1, S_B2, S_EX, S_W1, S_W2, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next, bc_reg, bc_next;
    logic [15:0] de_reg, de_next, hl_reg, hl_next;
    logic [7:0]  a_reg, a_next, op_reg, op_next, n1_reg, n1_next, n2_reg, n2_next;
    logic [7:0]  rd_reg, rd_next;
    logic [3:0]  f_reg, f_next;
    logic        halt_reg, halt_next;
    logic [4:0]  cost_reg, cost_next;
    logic [1:0]  kind_reg, kind_next;
    logic        rv_reg, rv_next;
    logic [7:0]  r8;
    logic [15:0] off;

    // Take a new request in the same cycle the pending result leaves.
    assign in_ready  = (state_reg == S_IDLE) && (!rv_reg || res_ready);
    assign res_valid = rv_reg;
    assign off       = {{8{n1_reg[7]}}, n1_reg};

    always_comb begin
        state_next = state_reg; pc_next = pc_reg; sp_next = sp_reg; bc_next = bc_reg;
        de_next = de_reg; hl_next = hl_reg; a_next = a_reg; op_next = op_reg;
        n1_next = n1_reg; n2_next = n2_reg; rd_next = rd_reg; f_next = f_reg;
        halt_next = halt_reg; cost_next = cost_reg; kind_next = kind_reg;
        rv_next = rv_reg && !res_ready;
        mreq = '0;
        r8 = 8'd0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    kind_next = in_kind; rd_next = 8'd0; cost_next = 5'd0;
                    op_next = 8'd0;
                    if (in_kind == KIND_WRITE) begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: in_addr, wdata: in_data};
                        rv_next = 1'b1;
                    end else if (in_kind == KIND_READ) begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: in_addr, wdata: 8'd0};
                        state_next = S_OUT;
                    end else if (in_kind == KIND_EXEC && !halt_reg) begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: pc_reg, wdata: 8'd0};
                        state_next = S_OP;
                    end else begin
                        rv_next = 1'b1;
                    end
                end
            end
            S_OUT: begin
                rd_next = mrdata; rv_next = 1'b1; state_next = S_IDLE;
            end
            S_OP: begin
                op_next = mrdata;
                case (mrdata)
                    OP_LD_BN, OP_LD_CN, OP_JR_NZ, OP_LD_AN, OP_LDH, PREFIX_CB,
                    OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_CALL: begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: pc_reg + 16'd1, wdata: 8'd0};
                        state_next = S_B1;
                    end
                    OP_LD_ADE: begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: de_reg, wdata: 8'd0};
                        state_next = S_B1;
                    end
                    OP_POP_BC, OP_RET: begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: sp_reg, wdata: 8'd0};
                        state_next = S_B1;
                    end
                    default: state_next = S_EX;
                endcase
            end
            S_B1: begin
                n1_next = mrdata;
                case (op_reg)
                    OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_CALL: begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: pc_reg + 16'd2, wdata: 8'd0};
                        state_next = S_B2;
                    end
                    OP_POP_BC, OP_RET: begin
                        mreq = '{en: 1'b1, we: 1'b0, addr: sp_reg + 16'd1, wdata: 8'd0};
                        state_next = S_B2;
                    end
                    default: state_next = S_EX;
                endcase
            end
            S_B2: begin
                n2_next = mrdata; state_next = S_EX;
            end
            S_EX: begin
                state_next = S_IDLE; rv_next = 1'b1;
                pc_next = pc_reg + 16'd1;
                case (op_reg)
                    OP_DEC_B: begin
                        r8 = bc_reg[15:8] - 8'd1;
                        f_next = (f_reg & FC) | FN | ((r8 == 8'd0) ? FZ : 4'd0)
                                 | ((bc_reg[11:8] == 4'd0) ? FH : 4'd0);
                        bc_next = {r8, bc_reg[7:0]}; cost_next = 5'd4;
                    end
                    OP_LD_BN: begin
                        bc_next = {n1_reg, bc_reg[7:0]}; pc_next = pc_reg + 16'd2;
                        cost_next = 5'd8;
                    end
                    OP_LD_CN: begin
                        bc_next = {bc_reg[15:8], n1_reg}; pc_next = pc_reg + 16'd2;
                        cost_next = 5'd8;
                    end
                    OP_LD_DE: begin
                        de_next = {n2_reg, n1_reg}; pc_next = pc_reg + 16'd3;
                        cost_next = 5'd12;
                    end
                    OP_LD_HL: begin
                        hl_next = {n2_reg, n1_reg}; pc_next = pc_reg + 16'd3;
                        cost_next = 5'd12;
                    end
                    OP_LD_SP: begin
                        sp_next = {n2_reg, n1_reg}; pc_next = pc_reg + 16'd3;
                        cost_next = 5'd12;
                    end
                    OP_RLA: begin
                        a_next = {a_reg[6:0], f_reg[0]};
                        f_next = a_reg[7] ? FC : 4'd0; cost_next = 5'd4;
                    end
                    OP_LD_ADE: begin
                        a_next = n1_reg; cost_next = 5'd8;
                    end
                    OP_JR_NZ: begin
                        if (f_reg[3] == 1'b0) begin
                            pc_next = pc_reg + off + 16'd2; cost_next = 5'd12;
                        end else begin
                            pc_next = pc_reg + 16'd2; cost_next = 5'd8;
                        end
                    end
                    OP_LDI: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: hl_reg, wdata: a_reg};
                        hl_next = hl_reg + 16'd1; cost_next = 5'd8;
                    end
                    OP_INC_HL: begin
                        hl_next = hl_reg + 16'd1; cost_next = 5'd8;
                    end
                    OP_LDD: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: hl_reg, wdata: a_reg};
                        hl_next = hl_reg - 16'd1; cost_next = 5'd8;
                    end
                    OP_LD_AN: begin
                        a_next = n1_reg; pc_next = pc_reg + 16'd2; cost_next = 5'd8;
                    end
                    OP_LD_CA: begin
                        bc_next = {bc_reg[15:8], a_reg}; cost_next = 5'd4;
                    end
                    OP_LD_HLA: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: hl_reg, wdata: a_reg};
                        cost_next = 5'd8;
                    end
                    OP_XOR_A: begin
                        a_next = 8'd0; f_next = FZ; cost_next = 5'd4;
                    end
                    OP_POP_BC: begin
                        bc_next = {n2_reg, n1_reg}; sp_next = sp_reg + 16'd2;
                        cost_next = 5'd12;
                    end
                    OP_PUSH: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: sp_reg - 16'd1,
                                 wdata: bc_reg[15:8]};
                        sp_next = sp_reg - 16'd2; cost_next = 5'd16;
                        rv_next = 1'b0; state_next = S_W1;
                    end
                    OP_RET: begin
                        pc_next = {n2_reg, n1_reg}; sp_next = sp_reg + 16'd2;
                        cost_next = 5'd16;
                    end
                    OP_CALL: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: sp_reg - 16'd1,
                                 wdata: 8'(pc_reg + 16'd3 >> 8)};
                        sp_next = sp_reg - 16'd2; pc_next = {n2_reg, n1_reg};
                        n2_next = 8'(pc_reg + 16'd3);
                        cost_next = 5'd24; rv_next = 1'b0; state_next = S_W2;
                    end
                    OP_LDH: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: HIGH_PAGE | {8'd0, n1_reg},
                                 wdata: a_reg};
                        pc_next = pc_reg + 16'd2; cost_next = 5'd12;
                    end
                    OP_LD_CIA: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: HIGH_PAGE | {8'd0, bc_reg[7:0]},
                                 wdata: a_reg};
                        cost_next = 5'd8;
                    end
                    PREFIX_CB: begin
                        if (n1_reg == CB_RL_C) begin
                            r8 = {bc_reg[6:0], f_reg[0]};
                            f_next = (bc_reg[7] ? FC : 4'd0) | ((r8 == 8'd0) ? FZ : 4'd0);
                            bc_next = {bc_reg[15:8], r8};
                            pc_next = pc_reg + 16'd2; cost_next = 5'd8;
                        end else if (n1_reg == CB_BIT7H) begin
                            f_next = (f_reg & FC) | FH | (hl_reg[15] ? 4'd0 : FZ);
                            pc_next = pc_reg + 16'd2; cost_next = 5'd8;
                        end else begin
                            halt_next = 1'b1;
                        end
                    end
                    default: halt_next = 1'b1;
                endcase
            end
            S_W1: begin
                mreq = '{en: 1'b1, we: 1'b1, addr: sp_reg, wdata: bc_reg[7:0]};
                rv_next = 1'b1; state_next = S_IDLE;
            end
            S_W2: begin
                mreq = '{en: 1'b1, we: 1'b1, addr: sp_reg, wdata: n2_reg};
                rv_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; rv_reg <= 1'b0; halt_reg <= 1'b0;
            pc_reg <= '0; sp_reg <= '0; bc_reg <= '0; de_reg <= '0; hl_reg <= '0;
            a_reg <= '0; f_reg <= '0;
        end else begin
            state_reg <= state_next; rv_reg <= rv_next; halt_reg <= halt_next;
            pc_reg <= pc_next; sp_reg <= sp_next; bc_reg <= bc_next; de_reg <= de_next;
            hl_reg <= hl_next; a_reg <= a_next; f_reg <= f_next;
        end
        op_reg <= op_next; n1_reg <= n1_next; n2_reg <= n2_next; rd_reg <= rd_next;
        cost_reg <= cost_next;
        kind_reg <= kind_next;
    end

    always_comb begin
        res.read_data       = rd_reg;
        res.program_counter = pc_reg;
        res.stack_pointer   = sp_reg;
        res.accumulator     = a_reg;
        res.flag_bits       = f_reg;
        res.halted_flag     = halt_reg;
        res.cycle_cost      = cost_reg;
        res.executed_opcode = op_reg;
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_busy_ready, aclk, aresetn, state_reg != S_IDLE, !in_ready,
        "ready raised while an instruction is in flight")
    `ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halt_reg, halt_reg,
        "halted state cleared")
    `ASSERT_IMPL(a_halt_cost, aclk, aresetn, rv_reg && halt_reg && kind_reg == KIND_EXEC
        && op_reg == 8'd0, res.cycle_cost == 5'd0, "halted execute reported a cost")
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the eight-bit CPU subset executor. Directed
// tests cover every opcode and the field extremes. A random phase follows
// that runs short programs written into memory ahead of each instruction,
// and a halting case closes the run. Every result is checked against a
// local model of the core.
// ----------------------------------------------------------------------------
module tb_top;
    import ebcpu_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 2000;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // Stimulus side.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
    logic [23:0] s_axis_tdata = '0;  // address[15:0], data[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;       // read_data, program_counter, stack_pointer,
                                     // accumulator, flag_bits, halted_flag,
                                     // cycle_cost, executed_opcode

    // Local model of the core state.
    logic [7:0]  mem_img [65536];
    bit          mem_valid [65536];
    int          valid_addrs[$];
    logic [15:0] pc_q, sp_q, bc_q, de_q, hl_q;
    logic [7:0]  acc_q;
    logic [3:0]  flags_q;
    logic        halt_q;

    result_t     expected_q[$];
    int          mismatches;
    int          cycles;
    int          requests_sent;
    int          burst_left;

    // Opcodes that the core knows; the prefix picks one of its two sub-ops.
    logic [7:0] known_ops [23] = '{OP_DEC_B, OP_LD_BN, OP_LD_CN, OP_LD_DE, OP_RLA,
        OP_LD_ADE, OP_JR_NZ, OP_LD_HL, OP_LDI, OP_INC_HL, OP_LD_SP, OP_LDD,
        OP_LD_AN, OP_LD_CA, OP_LD_HLA, OP_XOR_A, OP_POP_BC, OP_PUSH, OP_RET,
        OP_CALL, OP_LDH, OP_LD_CIA, PREFIX_CB};

    eight_bit_cpu_subset_executor_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Model of the core
    // ------------------------------------------------------------------------
    function automatic void mem_store(logic [15:0] a, logic [7:0] v);
        if (!mem_valid[a]) begin
            valid_addrs.push_back(a);
        end
        mem_valid[a] = 1'b1;
        mem_img[a] = v;
    endfunction

    function automatic logic [15:0] fetch_word(logic [15:0] a);
        return {mem_img[16'(a + 16'd1)], mem_img[a]};
    endfunction

    // Run one instruction against the model state; return its clock count.
    function automatic logic [4:0] run_instruction(logic [7:0] op);
        logic [15:0] npc, ret_addr;
        logic [7:0]  n1, b, c, r;
        logic [4:0]  cost;
        logic [15:0] len;
        logic        cy;
        npc = pc_q;
        n1 = mem_img[16'(pc_q + 16'd1)];
        b = bc_q[15:8];
        c = bc_q[7:0];
        cy = flags_q[0];
        cost = 5'd0;
        len = 16'd1;
        case (op)
            OP_DEC_B: begin
                r = b - 8'd1;
                flags_q = (flags_q & FC) | FN | ((r == 8'd0) ? FZ : 4'd0)
                        | ((b[3:0] == 4'd0) ? FH : 4'd0);
                bc_q = {r, c};
                cost = 5'd4;
            end
            OP_LD_BN: begin bc_q = {n1, c}; len = 16'd2; cost = 5'd8; end
            OP_LD_CN: begin bc_q = {b, n1}; len = 16'd2; cost = 5'd8; end
            OP_LD_DE: begin de_q = fetch_word(16'(pc_q + 16'd1)); len = 16'd3; cost = 5'd12; end
            OP_RLA: begin
                flags_q = acc_q[7] ? FC : 4'd0;
                acc_q = {acc_q[6:0], cy};
                cost = 5'd4;
            end
            OP_LD_ADE: begin acc_q = mem_img[de_q]; cost = 5'd8; end
            OP_JR_NZ: begin
                len = 16'd2;
                if (!flags_q[3]) begin
                    npc = npc + {{8{n1[7]}}, n1};
                    cost = 5'd12;
                end else begin
                    cost = 5'd8;
                end
            end
            OP_LD_HL: begin hl_q = fetch_word(16'(pc_q + 16'd1)); len = 16'd3; cost = 5'd12; end
            OP_LDI: begin mem_store(hl_q, acc_q); hl_q = hl_q + 16'd1; cost = 5'd8; end
            OP_INC_HL: begin hl_q = hl_q + 16'd1; cost = 5'd8; end
            OP_LD_SP: begin sp_q = fetch_word(16'(pc_q + 16'd1)); len = 16'd3; cost = 5'd12; end
            OP_LDD: begin mem_store(hl_q, acc_q); hl_q = hl_q - 16'd1; cost = 5'd8; end
            OP_LD_AN: begin acc_q = n1; len = 16'd2; cost = 5'd8; end
            OP_LD_CA: begin bc_q = {b, acc_q}; cost = 5'd4; end
            OP_LD_HLA: begin mem_store(hl_q, acc_q); cost = 5'd8; end
            OP_XOR_A: begin acc_q = 8'd0; flags_q = FZ; cost = 5'd4; end
            OP_POP_BC: begin
                bc_q = fetch_word(sp_q);
                sp_q = sp_q + 16'd2;
                cost = 5'd12;
            end
            OP_PUSH: begin
                sp_q = sp_q - 16'd1; mem_store(sp_q, b);
                sp_q = sp_q - 16'd1; mem_store(sp_q, c);
                cost = 5'd16;
            end
            OP_RET: begin
                npc = fetch_word(sp_q);
                sp_q = sp_q + 16'd2;
                len = 16'd0;
                cost = 5'd16;
            end
            OP_CALL: begin
                ret_addr = pc_q + 16'd3;
                npc = fetch_word(16'(pc_q + 16'd1));
                sp_q = sp_q - 16'd1; mem_store(sp_q, ret_addr[15:8]);
                sp_q = sp_q - 16'd1; mem_store(sp_q, ret_addr[7:0]);
                len = 16'd0;
                cost = 5'd24;
            end
            OP_LDH: begin mem_store(HIGH_PAGE + n1, acc_q); len = 16'd2; cost = 5'd12; end
            OP_LD_CIA: begin mem_store(HIGH_PAGE + c, acc_q); cost = 5'd8; end
            PREFIX_CB: begin
                if (n1 == CB_RL_C) begin
                    r = {c[6:0], cy};
                    flags_q = (c[7] ? FC : 4'd0) | ((r == 8'd0) ? FZ : 4'd0);
                    bc_q = {b, r};
                    len = 16'd2;
                    cost = 5'd8;
                end else if (n1 == CB_BIT7H) begin
                    flags_q = (flags_q & FC) | FH | (hl_q[15] ? 4'd0 : FZ);
                    len = 16'd2;
                    cost = 5'd8;
                end else begin
                    halt_q = 1'b1;
                end
            end
            default: halt_q = 1'b1;
        endcase
        pc_q = npc + len;
        return cost;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: bursts with random gaps, predicts each request's result
    // ------------------------------------------------------------------------
    task automatic send_request(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
        result_t exp;
        int gap;
        exp = '0;
        case (kind)
            KIND_WRITE: mem_store(addr, data);
            KIND_READ:  exp.read_data = mem_img[addr];
            KIND_EXEC: begin
                if (!halt_q) begin
                    exp.executed_opcode = mem_img[pc_q];
                    exp.cycle_cost = run_instruction(mem_img[pc_q]);
                end
            end
            default: ;
        endcase
        exp.program_counter = pc_q;
        exp.stack_pointer = sp_q;
        exp.accumulator = acc_q;
        exp.flag_bits = flags_q;
        exp.halted_flag = halt_q;
        expected_q.push_back(exp);

        // Pick a new burst length and an idle gap ahead of it.
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {data, addr};
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic fill_if_unwritten(logic [15:0] a);
        if (!mem_valid[a]) begin
            send_request(KIND_WRITE, a, 8'($urandom));
        end
    endtask

    // Place an instruction at the program counter and run it. Any memory
    // byte that the instruction will read and that is still unwritten is written first.
    task automatic run_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
        logic [15:0] at;
        int len;
        if (op == OP_LD_ADE) begin
            fill_if_unwritten(de_q);
        end
        if (op == OP_POP_BC || op == OP_RET) begin
            fill_if_unwritten(sp_q);
            fill_if_unwritten(16'(sp_q + 16'd1));
        end
        len = (op inside {OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_CALL}) ? 3 :
              (op inside {OP_LD_BN, OP_LD_CN, OP_JR_NZ, OP_LD_AN, OP_LDH, PREFIX_CB}) ? 2 : 1;
        at = pc_q;
        send_request(KIND_WRITE, at, op);
        if (len > 1) send_request(KIND_WRITE, 16'(at + 16'd1), b1);
        if (len > 2) send_request(KIND_WRITE, 16'(at + 16'd2), b2);
        send_request(KIND_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got, exp;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.read_data       = m_axis_tdata[7:0];
            got.program_counter = m_axis_tdata[23:8];
            got.stack_pointer   = m_axis_tdata[39:24];
            got.accumulator     = m_axis_tdata[47:40];
            got.flag_bits       = m_axis_tdata[51:48];
            got.halted_flag     = m_axis_tdata[52];
            got.cycle_cost      = m_axis_tdata[57:53];
            got.executed_opcode = m_axis_tdata[65:58];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp = expected_q.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: rd %h/%h pc %h/%h sp %h/%h a %h/%h f %h/%h",
                                 exp.read_data, got.read_data, exp.program_counter,
                                 got.program_counter, exp.stack_pointer, got.stack_pointer,
                                 exp.accumulator, got.accumulator, exp.flag_bits,
                                 got.flag_bits);
                        $display("          halt %b/%b cost %0d/%0d op %h/%h",
                                 exp.halted_flag, got.halted_flag, exp.cycle_cost,
                                 got.cycle_cost, exp.executed_opcode, got.executed_opcode);
                    end
                end
            end
        end
    end

    // Receiver stall pattern and run watchdog.
    int stall_mode;
    int stall_left;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("eight_bit_cpu_subset_executor_core regression: fail");
            $finish;
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(2);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(1));
            default: m_axis_tready <= ($urandom_range(3) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_loads();
        send_request(KIND_WRITE, 16'hFFFF, 8'hFF);
        send_request(KIND_READ, 16'hFFFF, 8'h00);
        run_op(OP_LD_BN, 8'hFF, 8'h00);
        run_op(OP_LD_CN, 8'h00, 8'h00);
        run_op(OP_LD_DE, 8'hFF, 8'hFF);
        run_op(OP_LD_HL, 8'h00, 8'h80);
        run_op(OP_LD_SP, 8'h00, 8'hD0);
        run_op(OP_LD_AN, 8'h80, 8'h00);
        run_op(OP_LD_CA, 8'h00, 8'h00);
        send_request(KIND_READ, 16'h0000, 8'hFF);
    endtask

    task automatic test_flag_ops();
        run_op(OP_DEC_B, 8'h00, 8'h00);        // no half borrow from low nibble
        run_op(OP_LD_BN, 8'h01, 8'h00);
        run_op(OP_DEC_B, 8'h00, 8'h00);        // result zero
        run_op(OP_DEC_B, 8'h00, 8'h00);        // wrap to FF, half borrow from low nibble
        run_op(OP_RLA, 8'h00, 8'h00);          // carry out, then carry in
        run_op(OP_RLA, 8'h00, 8'h00);
        run_op(PREFIX_CB, CB_RL_C, 8'h00);
        run_op(PREFIX_CB, CB_BIT7H, 8'h00);    // H bit set
        run_op(OP_INC_HL, 8'h00, 8'h00);
        run_op(OP_LD_HL, 8'h34, 8'h12);
        run_op(PREFIX_CB, CB_BIT7H, 8'h00);    // H bit clear
        run_op(OP_XOR_A, 8'h00, 8'h00);
    endtask

    task automatic test_memory_ops();
        run_op(OP_LD_AN, 8'h5A, 8'h00);
        run_op(OP_LDI, 8'h00, 8'h00);
        run_op(OP_LDD, 8'h00, 8'h00);
        run_op(OP_LD_HLA, 8'h00, 8'h00);
        run_op(OP_LDH, 8'hFF, 8'h00);
        run_op(OP_LD_CIA, 8'h00, 8'h00);
        send_request(KIND_READ, HIGH_PAGE + {8'h00, bc_q[7:0]}, 8'h00);
        run_op(OP_LD_DE, 8'h34, 8'h12);
        run_op(OP_LD_ADE, 8'h00, 8'h00);
    endtask

    task automatic test_stack_and_branch();
        run_op(OP_PUSH, 8'h00, 8'h00);
        run_op(OP_POP_BC, 8'h00, 8'h00);
        run_op(OP_CALL, 8'h00, 8'h40);
        run_op(OP_RET, 8'h00, 8'h00);
        run_op(OP_JR_NZ, 8'h00, 8'h00);        // Z set: fall through
        run_op(OP_DEC_B, 8'h00, 8'h00);
        run_op(OP_LD_BN, 8'h05, 8'h00);
        run_op(OP_DEC_B, 8'h00, 8'h00);        // clear Z
        run_op(OP_JR_NZ, 8'h80, 8'h00);        // farthest back
        run_op(OP_JR_NZ, 8'h7F, 8'h00);        // farthest forward
        send_request(KIND_RESERVED, 16'hA5A5, 8'h5A);   // reserved kind is ignored
    endtask

    task automatic test_random_programs();
        int pick, start;
        logic [7:0] op;
        start = requests_sent;
        while (requests_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                op = known_ops[$urandom_range(22)];
                if (op == PREFIX_CB) begin
                    run_op(op, $urandom_range(1) ? CB_RL_C : CB_BIT7H, 8'h00);
                end else begin
                    run_op(op, 8'($urandom), 8'($urandom));
                end
            end else if (pick < 82) begin
                send_request(KIND_WRITE, 16'($urandom), 8'($urandom));
            end else if (pick < 95) begin
                send_request(KIND_READ,
                             16'(valid_addrs[$urandom_range(valid_addrs.size() - 1)]),
                             8'($urandom));
            end else begin
                send_request(KIND_RESERVED, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    // Halting is sticky until reset, so it closes the run.
    task automatic test_halt();
        if ($urandom_range(1)) begin
            run_op(8'hD3, 8'h00, 8'h00);       // unknown opcode
        end else begin
            run_op(PREFIX_CB, 8'h00, 8'h00);   // unknown prefixed sub-op
        end
        send_request(KIND_EXEC, 16'h0000, 8'h00);
        send_request(KIND_WRITE, 16'h1234, 8'hC3);
        send_request(KIND_READ, 16'h1234, 8'h00);
        send_request(KIND_EXEC, 16'hFFFF, 8'hFF);
        send_request(KIND_RESERVED, 16'hFFFF, 8'hFF);
    endtask

    initial begin
        int drain;
        pc_q = '0; sp_q = '0; bc_q = '0; de_q = '0; hl_q = '0;
        acc_q = '0; flags_q = '0; halt_q = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_loads();
        test_flag_ops();
        test_memory_ops();
        test_stack_and_branch();
        test_random_programs();
        test_halt();

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (expected_q.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("eight_bit_cpu_subset_executor_core regression: pass");
        end else begin
            $display("eight_bit_cpu_subset_executor_core regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ebcpu_pkg.sv
sv/ebcpu_mem.sv
sv/ebcpu_seq.sv
sv/eight_bit_cpu_subset_executor_core.sv
verif/tb_top.sv
